[sv/mgq_pkg.sv]
// Shared constants, command and register codes, and pipeline payload types
// for the musical grid quantizer. No dependencies.
`default_nettype none

package mgq_pkg;

    // Position format
    localparam int POS_FRAC_BITS = 16;
    localparam int POS_WIDTH     = 48;

    // Field widths
    localparam int CNT_W      = 7;    // numerator, denominator, split count
    localparam int STR_W      = 17;   // strength, 1.0 = 1 << STR_FRAC
    localparam int STR_FRAC   = 16;
    localparam int CFG_W      = POS_WIDTH;
    localparam int CFG_IDX_W  = 2;

    // Four quarter notes in position format
    localparam int Q_W        = POS_FRAC_BITS + 3;
    // Step dividend: four quarters times the numerator
    localparam int X_W        = Q_W + CNT_W;
    // Divisor and remainder width, large enough for any grid step
    localparam int DIV_W      = X_W;
    // Magnitude of position minus origin
    localparam int MAG_W      = POS_WIDTH;
    localparam int DVND_W     = (MAG_W > X_W) ? MAG_W : X_W;
    localparam int DEN_PROD_W = 2 * CNT_W;

    // Blend arithmetic
    localparam int DELTA_W    = DIV_W + 1;
    localparam int PROD_W     = DELTA_W + STR_W + 1;
    localparam int BLEND_W    = PROD_W - STR_FRAC;
    localparam int SUM_W      = POS_WIDTH + 1;

    localparam logic [Q_W-1:0]       QUARTER4 = Q_W'(4) << POS_FRAC_BITS;
    localparam logic [STR_W-1:0]     STR_ONE  = STR_W'(1) << STR_FRAC;
    localparam logic [POS_WIDTH-1:0] POS_MAX  = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic [POS_WIDTH-1:0] POS_MIN  = {1'b1, {(POS_WIDTH-1){1'b0}}};

    // Grid kind of an item
    typedef enum logic [1:0] {
        CMD_BEAT  = 2'd0,
        CMD_BAR   = 2'd1,
        CMD_SPLIT = 2'd2
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM    = 2'd0,
        REG_DEN    = 2'd1,
        REG_ORIGIN = 2'd2
    } reg_idx_t;

    // Per-item data riding along the divider cells
    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos;
        logic [STR_W-1:0]            strength;
        logic                        neg;
        logic                        bypass;
    } mgq_item_t;

    // State held by one divider cell
    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  dvsr;
        logic [DVND_W-1:0] dvnd;
        logic [DIV_W-1:0]  quo;
        logic [MAG_W-1:0]  mag;
        mgq_item_t         item;
    } mgq_div_t;

endpackage

`default_nettype wire

[sv/mgq_div_cell.sv]
// One restoring-division cell: retires one dividend bit per transfer.
// Depends on mgq_pkg.
`default_nettype none

module mgq_div_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    input  mgq_pkg::mgq_div_t up_data,
    output logic             up_take,
    output logic             valid,
    output mgq_pkg::mgq_div_t data,
    input  logic             down_take
);
    import mgq_pkg::*;

    logic              valid_reg;
    mgq_div_t          data_reg;
    mgq_div_t          data_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              fits;

    // Shift in next dividend bit, subtract divisor when it fits
    always_comb
    begin
        trial     = {up_data.rem, up_data.dvnd[DVND_W-1]};
        diff      = trial - {1'b0, up_data.dvsr};
        fits      = (trial >= {1'b0, up_data.dvsr});
        data_next = up_data;
        data_next.rem  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        data_next.dvnd = up_data.dvnd << 1;
        data_next.quo  = {up_data.quo[DIV_W-2:0], fits};
    end

    // Loads when empty or when the neighbor takes the held item
    assign up_take = !valid_reg || down_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

[sv/mgq_blend.sv]
// Rounding to the nearest grid point, strength blend and saturation,
// three stages ending in the output register. Depends on mgq_pkg.
`default_nettype none

module mgq_blend (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 up_valid,
    input  mgq_pkg::mgq_div_t                    up_data,
    output logic                                 up_take,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mgq_pkg::POS_WIDTH-1:0] snapped_position
);
    import mgq_pkg::*;

    // Stage A: signed offset to nearest grid point
    logic                        a_valid_reg;
    logic signed [DELTA_W-1:0]   a_delta_reg;
    logic signed [POS_WIDTH-1:0] a_pos_reg;
    logic [STR_W-1:0]            a_str_reg;
    logic                        a_bypass_reg;
    // Stage B: offset times strength
    logic                        b_valid_reg;
    logic signed [PROD_W-1:0]    b_prod_reg;
    logic signed [POS_WIDTH-1:0] b_pos_reg;
    logic                        b_bypass_reg;
    // Output stage
    logic                        o_valid_reg;
    logic [POS_WIDTH-1:0]        o_pos_reg;

    logic                        a_take;
    logic                        b_take;
    logic                        o_take;

    logic [DIV_W-1:0]            rest;
    logic                        round_up;
    logic signed [DELTA_W-1:0]   drel;
    logic signed [DELTA_W-1:0]   a_delta_next;
    logic                        a_bypass_next;
    logic signed [PROD_W-1:0]    b_prod_next;
    logic signed [BLEND_W-1:0]   blend;
    logic signed [SUM_W-1:0]     sum;
    logic [POS_WIDTH-1:0]        o_pos_next;

    // Ready ripple from the output back
    assign o_take  = !o_valid_reg || !out_stall;
    assign b_take  = !b_valid_reg || o_take;
    assign a_take  = !a_valid_reg || b_take;
    assign up_take = a_take;

    // Nearest multiple, ties away from the origin
    always_comb
    begin
        rest          = up_data.dvsr - up_data.rem;
        round_up      = (up_data.rem >= rest);
        drel          = round_up ? $signed({1'b0, rest}) : -$signed({1'b0, up_data.rem});
        a_delta_next  = up_data.item.neg ? -drel : drel;
        a_bypass_next = up_data.item.bypass || (up_data.dvsr == '0);
    end

    // Blend product
    assign b_prod_next = a_delta_reg * $signed({1'b0, a_str_reg});

    // Arithmetic shift, add and saturate; bypass items keep their position
    always_comb
    begin
        blend = BLEND_W'(b_prod_reg >>> STR_FRAC);
        sum   = SUM_W'(b_pos_reg) + SUM_W'(blend);
        if (b_bypass_reg)
        begin
            o_pos_next = b_pos_reg;
        end
        else if (sum[SUM_W-1] != sum[SUM_W-2])
        begin
            o_pos_next = sum[SUM_W-1] ? POS_MIN : POS_MAX;
        end
        else
        begin
            o_pos_next = sum[POS_WIDTH-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_take)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_take)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (o_take)
            begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (a_take && up_valid)
        begin
            a_delta_reg  <= a_delta_next;
            a_pos_reg    <= up_data.item.pos;
            a_str_reg    <= up_data.item.strength;
            a_bypass_reg <= a_bypass_next;
        end
        if (b_take && a_valid_reg)
        begin
            b_prod_reg   <= b_prod_next;
            b_pos_reg    <= a_pos_reg;
            b_bypass_reg <= a_bypass_reg;
        end
        if (o_take && b_valid_reg)
        begin
            o_pos_reg <= o_pos_next;
        end
    end

    assign out_valid        = o_valid_reg;
    assign snapped_position = $signed(o_pos_reg);

endmodule

`default_nettype wire

[sv/musical_grid_quantizer_core.sv]
// Top level of the musical grid quantizer: configuration registers, input
// stage, two divider cell chains and the blend stages. Depends on mgq_pkg,
// mgq_div_cell and mgq_blend.
//
// One item is taken per clock while in_stall is low, and each gives one
// snapped position. From input transfer to output valid an item passes one
// input stage, 26 cells computing the grid step (one quotient bit each), 48
// cells computing the offset magnitude modulo the step (one bit each), and
// three blend stages. Each stage holds its item when the next stage is full
// and stalled, so in_stall rises only when every stage holds an item and the
// output is stalled. Configuration writes take effect for items accepted
// after the write; write only while no item is in flight.
`default_nettype none

module musical_grid_quantizer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [mgq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mgq_pkg::CFG_W-1:0]            cfg_data,
    // Input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           cmd,
    input  logic signed [mgq_pkg::POS_WIDTH-1:0] position,
    input  logic [mgq_pkg::CNT_W-1:0]            split_count,
    input  logic [mgq_pkg::STR_W-1:0]            strength,
    // Output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mgq_pkg::POS_WIDTH-1:0] snapped_position
);
    import mgq_pkg::*;

    // Configuration registers
    logic [CNT_W-1:0]            beats_per_bar_reg;
    logic [CNT_W-1:0]            beat_note_value_reg;
    logic signed [POS_WIDTH-1:0] origin_position_reg;

    // Input stage
    logic                        front_valid_reg;
    mgq_div_t                    front_reg;
    mgq_div_t                    front_next;
    logic                        front_take;

    logic [CNT_W-1:0]            num;
    logic [CNT_W-1:0]            den;
    logic [CNT_W-1:0]            parts;
    logic [DEN_PROD_W-1:0]       den_parts;
    logic [X_W-1:0]              step_dvnd;
    logic [DIV_W-1:0]            step_dvsr;
    logic                        no_grid;
    logic signed [SUM_W-1:0]     rel;
    logic signed [SUM_W-1:0]     rel_abs;

    // Cell chains
    logic                        c1_valid [X_W];
    mgq_div_t                    c1_data  [X_W];
    logic                        c1_take  [X_W];
    logic                        c2_valid [MAG_W];
    mgq_div_t                    c2_data  [MAG_W];
    logic                        c2_take  [MAG_W];
    mgq_div_t                    c2_entry;
    logic                        blend_take;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beats_per_bar_reg   <= CNT_W'(4);
            beat_note_value_reg <= CNT_W'(4);
            origin_position_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM:    beats_per_bar_reg   <= cfg_data[CNT_W-1:0];
                REG_DEN:    beat_note_value_reg <= cfg_data[CNT_W-1:0];
                REG_ORIGIN: origin_position_reg <= $signed(cfg_data[POS_WIDTH-1:0]);
                default:    ;
            endcase
        end
    end

    // Step dividend and divisor, offset from origin, clamped strength
    always_comb
    begin
        num       = (beats_per_bar_reg == '0) ? CNT_W'(1) : beats_per_bar_reg;
        den       = (beat_note_value_reg == '0) ? CNT_W'(1) : beat_note_value_reg;
        parts     = (split_count == '0) ? CNT_W'(1) : split_count;
        den_parts = DEN_PROD_W'(den) * DEN_PROD_W'(parts);
        no_grid   = 1'b0;
        case (cmd)
            CMD_BEAT:
            begin
                step_dvnd = X_W'(QUARTER4);
                step_dvsr = DIV_W'(den);
            end
            CMD_BAR:
            begin
                step_dvnd = X_W'(num) << (POS_FRAC_BITS + 2);
                step_dvsr = DIV_W'(den);
            end
            CMD_SPLIT:
            begin
                step_dvnd = X_W'(QUARTER4);
                step_dvsr = DIV_W'(den_parts);
            end
            default:
            begin
                step_dvnd = X_W'(QUARTER4);
                step_dvsr = DIV_W'(1);
                no_grid   = 1'b1;
            end
        endcase

        rel     = SUM_W'(position) - SUM_W'(origin_position_reg);
        rel_abs = rel[SUM_W-1] ? -rel : rel;

        front_next.rem           = '0;
        front_next.dvsr          = step_dvsr;
        front_next.dvnd          = DVND_W'(step_dvnd) << (DVND_W - X_W);
        front_next.quo           = '0;
        front_next.mag           = rel_abs[MAG_W-1:0];
        front_next.item.pos      = position;
        front_next.item.strength = (strength > STR_ONE) ? STR_ONE : strength;
        front_next.item.neg      = rel[SUM_W-1];
        front_next.item.bypass   = no_grid;
    end

    assign front_take = !front_valid_reg || c1_take[0];
    assign in_stall   = !front_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (front_take)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_take && in_valid)
        begin
            front_reg <= front_next;
        end
    end

    // Step chain: quotient of step dividend by divisor
    for (genvar i = 0; i < X_W; i++)
    begin : g_step
        if (i == 0)
        begin : g_first
            mgq_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .up_valid  (front_valid_reg),
                .up_data   (front_reg),
                .up_take   (c1_take[i]),
                .valid     (c1_valid[i]),
                .data      (c1_data[i]),
                .down_take ((i == X_W - 1) ? c2_take[0] : c1_take[(i + 1) % X_W])
            );
        end
        else
        begin : g_rest
            mgq_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .up_valid  (c1_valid[i-1]),
                .up_data   (c1_data[i-1]),
                .up_take   (c1_take[i]),
                .valid     (c1_valid[i]),
                .data      (c1_data[i]),
                .down_take ((i == X_W - 1) ? c2_take[0] : c1_take[(i + 1) % X_W])
            );
        end
    end

    // Hand the step over as divisor, the offset magnitude as dividend
    always_comb
    begin
        c2_entry      = c1_data[X_W-1];
        c2_entry.rem  = '0;
        c2_entry.dvsr = c1_data[X_W-1].quo;
        c2_entry.dvnd = DVND_W'(c1_data[X_W-1].mag) << (DVND_W - MAG_W);
        c2_entry.quo  = '0;
    end

    // Remainder chain: offset magnitude modulo step
    for (genvar j = 0; j < MAG_W; j++)
    begin : g_mod
        if (j == 0)
        begin : g_first
            mgq_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .up_valid  (c1_valid[X_W-1]),
                .up_data   (c2_entry),
                .up_take   (c2_take[j]),
                .valid     (c2_valid[j]),
                .data      (c2_data[j]),
                .down_take ((j == MAG_W - 1) ? blend_take : c2_take[(j + 1) % MAG_W])
            );
        end
        else
        begin : g_rest
            mgq_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .up_valid  (c2_valid[j-1]),
                .up_data   (c2_data[j-1]),
                .up_take   (c2_take[j]),
                .valid     (c2_valid[j]),
                .data      (c2_data[j]),
                .down_take ((j == MAG_W - 1) ? blend_take : c2_take[(j + 1) % MAG_W])
            );
        end
    end

    // Round, blend, saturate, output register
    mgq_blend u_blend (
        .clk              (clk),
        .rst_n            (rst_n),
        .up_valid         (c2_valid[MAG_W-1]),
        .up_data          (c2_data[MAG_W-1]),
        .up_take          (blend_take),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .snapped_position (snapped_position)
    );

    // Input stalls only while the input stage is occupied
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> front_valid_reg)
        else $error("input stalled with empty input stage");

    // Any grid kind yields a nonzero step
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        c1_valid[X_W-1] && !c1_data[X_W-1].item.bypass |-> c1_data[X_W-1].quo != '0)
        else $error("grid step is zero");

    // Remainder chain ends below the step
    a_rem_below_step: assert property (@(posedge clk) disable iff (!rst_n)
        c2_valid[MAG_W-1] && !c2_data[MAG_W-1].item.bypass
            |-> c2_data[MAG_W-1].rem < c2_data[MAG_W-1].dvsr)
        else $error("remainder not below step");

endmodule

`default_nettype wire
